@@ rtl/skrq_pkg.sv @@
// ----------------------------------------------------------------------------
// skrq_pkg
// Shared types, constants and helpers of the stick key repeat queue.
// ----------------------------------------------------------------------------
package skrq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int PEND_W      = 4;
  localparam int NUM_KEYS    = 6;
  localparam int NUM_DIRS    = 4;

  localparam logic [14:0] THRESHOLD_RESET = 15'd18022;
  localparam logic [15:0] INTERVAL_RESET  = 16'd300;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_READ   = 2'd1,
    OP_PEEK   = 2'd2,
    OP_FLUSH  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_STICK_THRESHOLD = 3'd0,
    REG_REPEAT_INTERVAL = 3'd1,
    REG_KEY_UP          = 3'd2,
    REG_KEY_DOWN        = 3'd3,
    REG_KEY_LEFT        = 3'd4,
    REG_KEY_RIGHT       = 3'd5,
    REG_KEY_ENTER       = 3'd6,
    REG_KEY_ESCAPE      = 3'd7
  } reg_index_t;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct packed {
    logic [14:0]                 threshold;
    logic [15:0]                 interval;
    logic [NUM_KEYS-1:0][7:0]    keys;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] stick_x;
    logic signed [15:0] stick_y;
    logic               button_a;
    logic               button_b;
    logic [31:0]        now_ms;
  } sample_t;

  typedef struct packed {
    op_t                 op;
    logic [NUM_KEYS-1:0] push;
  } cmd_t;

  function automatic ptr_t ptr_inc(input ptr_t p);
    return (p == ptr_t'(QUEUE_DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
  endfunction

  function automatic ptr_t fifo_cnt(input ptr_t wp, input ptr_t rp);
    logic [PTR_W:0] diff;
    diff = (wp >= rp) ? ({1'b0, wp} - {1'b0, rp})
                      : ({1'b0, wp} + (PTR_W+1)'(QUEUE_DEPTH) - {1'b0, rp});
    return diff[PTR_W-1:0];
  endfunction

endpackage

@@ rtl/stick_key_repeat_queue.sv @@
// ----------------------------------------------------------------------------
// stick_key_repeat_queue
// Stick and button samples to menu key codes through a key FIFO.
// ----------------------------------------------------------------------------
// Input stream: s_tuser carries the request kind (sample, read, peek, flush),
// s_tdata carries the stick and button sample with its millisecond time.
// Output stream: one result per request: head key code, a key-valid flag on
// m_tuser and the number of keys left queued.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while idle, the block itself does not enforce this.
// Path: the front writes the request queue, the back the output register.
// Throughput: 1 request per cycle while the receiver does not stall; the
// back part does all FIFO pushes of a sample and the read at once, the front
// part one sample compare and four deadline checks at once.
// Reset: pressed state, deadlines, FIFO pointers and configuration return to
// their defaults; the key FIFO is empty.
// Receiver stall: the output register holds, the back part stops, the
// two-entry request queue fills, then s_tready drops.
// ----------------------------------------------------------------------------
module stick_key_repeat_queue import skrq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // stick_x[15:0], stick_y[31:16], button_a[32], button_b[33], now_ms[65:34]
  input  logic [71:0] s_tdata,
  // op[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // key_code[7:0], pending_keys[11:8]
  output logic [15:0] m_tdata,
  // key_valid[0]
  output logic        m_tuser,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t              cfg;
  sample_t           sample;
  op_t               op;
  cmd_t              front_cmd;
  cmd_t              back_cmd;
  logic              front_valid;
  logic              front_ready;
  logic              back_valid;
  logic              back_ready;
  logic [7:0]        code;
  logic [PEND_W-1:0] pending;

  assign op              = op_t'(s_tuser);
  assign sample.stick_x  = s_tdata[15:0];
  assign sample.stick_y  = s_tdata[31:16];
  assign sample.button_a = s_tdata[32];
  assign sample.button_b = s_tdata[33];
  assign sample.now_ms   = s_tdata[65:34];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold <= THRESHOLD_RESET;
      cfg.interval  <= INTERVAL_RESET;
      cfg.keys      <= '0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_STICK_THRESHOLD: cfg.threshold <= cfg_data[14:0];
        REG_REPEAT_INTERVAL: cfg.interval  <= cfg_data;
        REG_KEY_UP:          cfg.keys[0]   <= cfg_data[7:0];
        REG_KEY_DOWN:        cfg.keys[1]   <= cfg_data[7:0];
        REG_KEY_LEFT:        cfg.keys[2]   <= cfg_data[7:0];
        REG_KEY_RIGHT:       cfg.keys[3]   <= cfg_data[7:0];
        REG_KEY_ENTER:       cfg.keys[4]   <= cfg_data[7:0];
        REG_KEY_ESCAPE:      cfg.keys[5]   <= cfg_data[7:0];
        default: begin
          cfg.threshold <= cfg.threshold;
        end
      endcase
    end
  end

  skrq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (op),
    .in_sample (sample),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  skrq_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_cmd   (front_cmd),
    .rd_valid (back_valid),
    .rd_ready (back_ready),
    .rd_cmd   (back_cmd)
  );

  skrq_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd_valid     (back_valid),
    .cmd_ready     (back_ready),
    .cmd           (back_cmd),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_code      (code),
    .out_key_valid (m_tuser),
    .out_pending   (pending)
  );

  assign m_tdata = {4'b0, pending, code};

endmodule

@@ rtl/skrq_front.sv @@
// ----------------------------------------------------------------------------
// skrq_front
// Classifies requests: stick and button edges, auto-repeat deadlines.
// ----------------------------------------------------------------------------
module skrq_front import skrq_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    in_valid,
  output logic    in_ready,
  input  op_t     in_op,
  input  sample_t in_sample,
  output logic    cmd_valid,
  input  logic    cmd_ready,
  output cmd_t    cmd
);

  logic [5:0]                  pressed_prev;
  logic [NUM_DIRS-1:0][31:0]   repeat_due;

  logic signed [16:0]  x17;
  logic signed [16:0]  y17;
  logic signed [16:0]  thr17;
  logic [NUM_DIRS-1:0] held;
  logic [NUM_DIRS-1:0] dir_push;
  logic [31:0]         due_new;
  logic [31:0]         diff [NUM_DIRS];
  logic                accept;
  logic                is_sample;

  assign x17     = {in_sample.stick_x[15], in_sample.stick_x};
  assign y17     = {in_sample.stick_y[15], in_sample.stick_y};
  assign thr17   = {2'b00, cfg.threshold};
  assign held[0] = y17 < -thr17;
  assign held[1] = y17 > thr17;
  assign held[2] = x17 < -thr17;
  assign held[3] = x17 > thr17;
  assign due_new = in_sample.now_ms + {16'b0, cfg.interval};

  always_comb begin
    for (int i = 0; i < NUM_DIRS; i++) begin
      diff[i]     = in_sample.now_ms - repeat_due[i];
      dir_push[i] = held[i] & (~pressed_prev[i] | ~diff[i][31]);
    end
  end

  assign is_sample = (in_op == OP_SAMPLE);
  assign in_ready  = cmd_ready;
  assign accept    = in_valid & in_ready;
  assign cmd_valid = in_valid;
  assign cmd.op    = in_op;
  assign cmd.push  = is_sample ? {in_sample.button_b & ~pressed_prev[5],
                                  in_sample.button_a & ~pressed_prev[4],
                                  dir_push} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pressed_prev <= '0;
      repeat_due   <= '0;
    end else if (accept && is_sample) begin
      pressed_prev <= {in_sample.button_b, in_sample.button_a, held};
      for (int i = 0; i < NUM_DIRS; i++) begin
        if (dir_push[i]) begin
          repeat_due[i] <= due_new;
        end
      end
    end
  end

endmodule

@@ rtl/skrq_cmd_queue.sv @@
// ----------------------------------------------------------------------------
// skrq_cmd_queue
// Two-entry queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module skrq_cmd_queue import skrq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  cmd_t wr_cmd,
  output logic rd_valid,
  input  logic rd_ready,
  output cmd_t rd_cmd
);

  cmd_t       slot [2];
  logic       wr_sel;
  logic       rd_sel;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_cmd   = slot[rd_sel];
  assign push     = wr_valid & wr_ready;
  assign pop      = rd_valid & rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_sel <= 1'b0;
      rd_sel <= 1'b0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_sel <= ~wr_sel;
      end
      if (pop) begin
        rd_sel <= ~rd_sel;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_sel] <= wr_cmd;
    end
  end

endmodule

@@ rtl/skrq_back.sv @@
// ----------------------------------------------------------------------------
// skrq_back
// Key FIFO: up to six pushes or one read, peek or flush per request.
// ----------------------------------------------------------------------------
module skrq_back import skrq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  cmd_t              cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_code,
  output logic              out_key_valid,
  output logic [PEND_W-1:0] out_pending
);

  logic [7:0] key_store [QUEUE_DEPTH];
  ptr_t       write_pos;
  ptr_t       read_pos;
  ptr_t       write_pos_next;
  ptr_t       read_pos_next;

  logic                go;
  ptr_t                cnt;
  ptr_t                cnt_v;
  ptr_t                wp_v;
  logic [7:0]          first_code;
  logic [NUM_KEYS-1:0] wr_en;
  ptr_t                wr_addr [NUM_KEYS];
  logic [7:0]          head;
  logic [7:0]          code_next;
  logic                valid_next;
  ptr_t                pend_next;

  assign cmd_ready = ~out_valid | out_ready;
  assign go        = cmd_valid & cmd_ready;
  assign cnt       = fifo_cnt(write_pos, read_pos);
  assign head      = key_store[read_pos];

  always_comb begin
    wp_v       = write_pos;
    cnt_v      = cnt;
    first_code = '0;
    wr_en      = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      wr_addr[i] = wp_v;
      if (cmd.op == OP_SAMPLE && cmd.push[i] && cnt_v != ptr_t'(QUEUE_DEPTH - 1)) begin
        wr_en[i] = 1'b1;
        if (cnt_v == '0) begin
          first_code = cfg.keys[i];
        end
        wp_v  = ptr_inc(wp_v);
        cnt_v = ptr_t'(cnt_v + 1'b1);
      end
    end

    write_pos_next = write_pos;
    read_pos_next  = read_pos;
    code_next      = '0;
    valid_next     = 1'b0;
    pend_next      = cnt;
    case (cmd.op)
      OP_SAMPLE: begin
        write_pos_next = wp_v;
        valid_next     = (cnt_v != '0);
        code_next      = (cnt != '0) ? head : first_code;
        pend_next      = cnt_v;
      end
      OP_READ, OP_PEEK: begin
        valid_next = (cnt != '0);
        code_next  = (cnt != '0) ? head : '0;
        if (cmd.op == OP_READ && cnt != '0) begin
          read_pos_next = ptr_inc(read_pos);
          pend_next     = ptr_t'(cnt - 1'b1);
        end
      end
      OP_FLUSH: begin
        write_pos_next = '0;
        read_pos_next  = '0;
        pend_next      = '0;
      end
      default: begin
        pend_next = cnt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos <= '0;
      read_pos  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (go) begin
        write_pos <= write_pos_next;
        read_pos  <= read_pos_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_code      <= code_next;
      out_key_valid <= valid_next;
      out_pending   <= PEND_W'(pend_next);
      for (int i = 0; i < NUM_KEYS; i++) begin
        if (wr_en[i]) begin
          key_store[wr_addr[i]] <= cfg.keys[i];
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    go && cmd.op == OP_FLUSH |=> write_pos == '0 && read_pos == '0)
    else $error("flush did not clear queue pointers");

  a_peek_holds: assert property (@(posedge clk) disable iff (rst)
    go && cmd.op == OP_PEEK |=> $stable(write_pos) && $stable(read_pos))
    else $error("peek moved queue pointers");

  a_read_pops: assert property (@(posedge clk) disable iff (rst)
    go && cmd.op == OP_READ && cnt != '0 |=> read_pos == ptr_inc($past(read_pos)))
    else $error("read of non-empty queue did not advance head");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(write_pos) && $stable(read_pos))
    else $error("queue pointers moved while result stalled");
`endif

endmodule
